@@ hw/rtl/ubxfr_pkg.sv @@
// shared types and constants of the frame receiver
// no dependencies
package ubxfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;
    localparam logic [7:0] FILTER_ANY  = 8'hFF;

    localparam int unsigned FRAME_OVERHEAD = 8;
    localparam int unsigned PAYLOAD_START  = 6;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SYNC  = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;
    localparam logic [1:0] ERR_CHECK = 2'd3;

    localparam logic CFG_CLASS = 1'b0;
    localparam logic CFG_IDENT = 1'b1;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_HEADER,
        PH_BODY
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RDCAP,
        S_SETTLE,
        S_HDR_RD,
        S_HDR_CAP,
        S_HDR_CHK,
        S_CK_RD,
        S_CK_CAP,
        S_SCAN_RD,
        S_SCAN_CAP,
        S_MOVE_RD,
        S_MOVE_CAP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic clr;
        logic add;
    } fl_ctrl_t;

endpackage

@@ hw/rtl/ubx_frame_receiver.sv @@
// top level of the binary frame receiver: sequencer, header registers, output register
// depends on ubxfr_pkg, ubxfr_ram, ubxfr_fletcher
//
// The receiver takes one beat at a time and is busy until its result is formed.
// A read beat (tuser 1) passes through dispatch, a capture state when the
// offset is in range, and emit. A received byte that does not complete a header
// or a frame passes through dispatch and emit while a start byte is sought, and
// through dispatch, settle and emit otherwise. Once eight bytes are held the
// header is read back from the frame store, a read and a capture state a byte,
// and the byte that ends a frame runs the checksum through the single fletcher
// unit, a read and a capture state per byte from class to the second checksum
// byte. On a framing error the sequencer scans the retained bytes for the next
// 0xB5 and moves the rest down to offset zero, a read and a capture state a
// byte in each pass, then checks the header again; all store traffic goes
// through the one read port and one write port of the store. The result
// register holds a finished result while the next beat is taken. There is no clearing
// pass: a read of a store entry never written since reset returns undefined data.
module ubx_frame_receiver #(
    parameter int BUFFER_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte [7:0], read_offset [15:8]
    input  logic        s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_valid [0], frame_match [1], msg_class [9:2], msg_ident [17:10],
    // frame_payload_len [25:18], error_code [27:26], read_data [35:28], read_ok [36]
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int LW = AW;

    // configuration
    logic [7:0] class_filter_reg;
    logic [7:0] id_filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_filter_reg <= ubxfr_pkg::FILTER_ANY;
            id_filter_reg    <= ubxfr_pkg::FILTER_ANY;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ubxfr_pkg::CFG_CLASS: class_filter_reg <= cfg_wdata;
                ubxfr_pkg::CFG_IDENT: id_filter_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer and receive state
    ubxfr_pkg::state_t state_reg, state_next;
    ubxfr_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next;
    logic [LW-1:0] spl_reg, spl_next;      // stored payload length
    logic [CW-1:0] idx_reg, idx_next;      // store walk pointer
    logic [CW-1:0] shift_reg, shift_next;  // resync distance

    // latched beat
    logic       cmd_reg, cmd_next;
    logic [7:0] byte_reg, byte_next;
    logic [7:0] off_reg, off_next;

    // header bytes read back from the store
    logic [7:0] sync2_reg, sync2_next;
    logic [7:0] cls_reg, cls_next;
    logic [7:0] ident_reg, ident_next;
    logic [7:0] lenlo_reg, lenlo_next;
    logic [7:0] lenhi_reg, lenhi_next;
    logic [7:0] cka_reg, cka_next;

    // result being formed
    logic       rv_reg, rv_next;
    logic       rm_reg, rm_next;
    logic [7:0] rcls_reg, rcls_next;
    logic [7:0] rid_reg, rid_next;
    logic [7:0] rlen_reg, rlen_next;
    logic [1:0] err_reg, err_next;
    logic [7:0] rdat_reg, rdat_next;
    logic       rok_reg, rok_next;

    // output register
    logic        mv_reg;
    logic [39:0] md_reg;

    // store and checksum unit
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    ubxfr_pkg::fl_ctrl_t fl_ctrl;
    logic [7:0]          fl_a;
    logic [7:0]          fl_b;

    ubxfr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ubxfr_fletcher u_fletcher (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fl_ctrl),
        .data  (ram_rdata),
        .sum_a (fl_a),
        .sum_b (fl_b)
    );

    // derived values
    logic          s_fire;
    logic          emit_go;
    logic          read_in_range;
    logic [15:0]   hdr_len;
    logic          hdr_too_long;
    logic [CW-1:0] frame_end;
    logic [CW-1:0] ck_pos;
    logic          filter_pass;

    assign s_fire        = s_tvalid && s_tready;
    assign emit_go       = (state_reg == ubxfr_pkg::S_EMIT) && (!mv_reg || m_tready);
    assign read_in_range = (32'(off_reg) < 32'(spl_reg))
                        && ((32'(off_reg) + ubxfr_pkg::PAYLOAD_START) < 32'(BUFFER_BYTES));
    assign hdr_len       = {lenhi_reg, lenlo_reg};
    assign hdr_too_long  = (32'(hdr_len) + ubxfr_pkg::FRAME_OVERHEAD) > 32'(BUFFER_BYTES);
    assign frame_end     = CW'(spl_reg) + CW'(ubxfr_pkg::FRAME_OVERHEAD);
    assign ck_pos        = CW'(spl_reg) + CW'(ubxfr_pkg::PAYLOAD_START);
    assign filter_pass   = ((class_filter_reg == ubxfr_pkg::FILTER_ANY)
                            || (class_filter_reg == cls_reg))
                        && ((id_filter_reg == ubxfr_pkg::FILTER_ANY)
                            || (id_filter_reg == ident_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ubxfr_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = ubxfr_pkg::S_DISPATCH;
                end
            end
            ubxfr_pkg::S_DISPATCH:
            begin
                if (cmd_reg)
                begin
                    state_next = read_in_range ? ubxfr_pkg::S_RDCAP : ubxfr_pkg::S_EMIT;
                end
                else if (phase_reg == ubxfr_pkg::PH_SEEK)
                begin
                    state_next = ubxfr_pkg::S_EMIT;
                end
                else if (32'(count_reg) >= 32'(BUFFER_BYTES))
                begin
                    state_next = ubxfr_pkg::S_EMIT;
                end
                else
                begin
                    state_next = ubxfr_pkg::S_SETTLE;
                end
            end
            ubxfr_pkg::S_RDCAP:
            begin
                state_next = ubxfr_pkg::S_EMIT;
            end
            ubxfr_pkg::S_SETTLE:
            begin
                if (phase_reg == ubxfr_pkg::PH_HEADER)
                begin
                    state_next = (count_reg < CW'(ubxfr_pkg::FRAME_OVERHEAD))
                               ? ubxfr_pkg::S_EMIT : ubxfr_pkg::S_HDR_RD;
                end
                else if (phase_reg == ubxfr_pkg::PH_BODY)
                begin
                    state_next = (count_reg < frame_end)
                               ? ubxfr_pkg::S_EMIT : ubxfr_pkg::S_CK_RD;
                end
                else
                begin
                    state_next = ubxfr_pkg::S_EMIT;
                end
            end
            ubxfr_pkg::S_HDR_RD:
            begin
                state_next = ubxfr_pkg::S_HDR_CAP;
            end
            ubxfr_pkg::S_HDR_CAP:
            begin
                state_next = (idx_reg == CW'(5)) ? ubxfr_pkg::S_HDR_CHK : ubxfr_pkg::S_HDR_RD;
            end
            ubxfr_pkg::S_HDR_CHK:
            begin
                if ((sync2_reg != ubxfr_pkg::SYNC_SECOND) || hdr_too_long)
                begin
                    state_next = ubxfr_pkg::S_SCAN_RD;
                end
                else
                begin
                    state_next = ubxfr_pkg::S_SETTLE;
                end
            end
            ubxfr_pkg::S_CK_RD:
            begin
                state_next = ubxfr_pkg::S_CK_CAP;
            end
            ubxfr_pkg::S_CK_CAP:
            begin
                if (idx_reg == ck_pos + CW'(1))
                begin
                    state_next = ((cka_reg == fl_a) && (ram_rdata == fl_b))
                               ? ubxfr_pkg::S_EMIT : ubxfr_pkg::S_SCAN_RD;
                end
                else
                begin
                    state_next = ubxfr_pkg::S_CK_RD;
                end
            end
            ubxfr_pkg::S_SCAN_RD:
            begin
                state_next = (idx_reg >= count_reg) ? ubxfr_pkg::S_EMIT : ubxfr_pkg::S_SCAN_CAP;
            end
            ubxfr_pkg::S_SCAN_CAP:
            begin
                state_next = (ram_rdata == ubxfr_pkg::SYNC_FIRST)
                           ? ubxfr_pkg::S_MOVE_RD : ubxfr_pkg::S_SCAN_RD;
            end
            ubxfr_pkg::S_MOVE_RD:
            begin
                state_next = (idx_reg >= count_reg - shift_reg)
                           ? ubxfr_pkg::S_SETTLE : ubxfr_pkg::S_MOVE_CAP;
            end
            ubxfr_pkg::S_MOVE_CAP:
            begin
                state_next = ubxfr_pkg::S_MOVE_RD;
            end
            ubxfr_pkg::S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ubxfr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ubxfr_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        spl_next   = spl_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        cmd_next   = cmd_reg;
        byte_next  = byte_reg;
        off_next   = off_reg;
        sync2_next = sync2_reg;
        cls_next   = cls_reg;
        ident_next = ident_reg;
        lenlo_next = lenlo_reg;
        lenhi_next = lenhi_reg;
        cka_next   = cka_reg;
        rv_next    = rv_reg;
        rm_next    = rm_reg;
        rcls_next  = rcls_reg;
        rid_next   = rid_reg;
        rlen_next  = rlen_reg;
        err_next   = err_reg;
        rdat_next  = rdat_reg;
        rok_next   = rok_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = byte_reg;
        ram_raddr  = idx_reg[AW-1:0];
        fl_ctrl    = '0;

        case (state_reg)
            ubxfr_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next  = s_tuser;
                    byte_next = s_tdata[7:0];
                    off_next  = s_tdata[15:8];
                    rv_next   = 1'b0;
                    rm_next   = 1'b0;
                    rcls_next = 8'd0;
                    rid_next  = 8'd0;
                    rlen_next = 8'd0;
                    err_next  = ubxfr_pkg::ERR_NONE;
                    rdat_next = 8'd0;
                    rok_next  = 1'b0;
                end
            end
            ubxfr_pkg::S_DISPATCH:
            begin
                ram_raddr = AW'(32'(off_reg) + ubxfr_pkg::PAYLOAD_START);
                if (!cmd_reg)
                begin
                    if (phase_reg == ubxfr_pkg::PH_SEEK)
                    begin
                        if (byte_reg == ubxfr_pkg::SYNC_FIRST)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            count_next = CW'(1);
                            phase_next = ubxfr_pkg::PH_HEADER;
                        end
                    end
                    else if (32'(count_reg) >= 32'(BUFFER_BYTES))
                    begin
                        count_next = '0;
                        phase_next = ubxfr_pkg::PH_SEEK;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ubxfr_pkg::S_RDCAP:
            begin
                rdat_next = ram_rdata;
                rok_next  = 1'b1;
            end
            ubxfr_pkg::S_SETTLE:
            begin
                if (phase_reg == ubxfr_pkg::PH_HEADER)
                begin
                    idx_next = CW'(1);
                end
                else
                begin
                    idx_next = CW'(2);
                    fl_ctrl.clr = 1'b1;
                end
            end
            ubxfr_pkg::S_HDR_CAP:
            begin
                case (idx_reg[2:0])
                    3'd1: sync2_next = ram_rdata;
                    3'd2: cls_next   = ram_rdata;
                    3'd3: ident_next = ram_rdata;
                    3'd4: lenlo_next = ram_rdata;
                    3'd5: lenhi_next = ram_rdata;
                    default: ;
                endcase
                idx_next = idx_reg + CW'(1);
            end
            ubxfr_pkg::S_HDR_CHK:
            begin
                idx_next = CW'(1);
                if (sync2_reg != ubxfr_pkg::SYNC_SECOND)
                begin
                    if (err_reg == ubxfr_pkg::ERR_NONE)
                    begin
                        err_next = ubxfr_pkg::ERR_SYNC;
                    end
                end
                else if (hdr_too_long)
                begin
                    if (err_reg == ubxfr_pkg::ERR_NONE)
                    begin
                        err_next = ubxfr_pkg::ERR_LONG;
                    end
                end
                else
                begin
                    spl_next   = hdr_len[LW-1:0];
                    phase_next = ubxfr_pkg::PH_BODY;
                end
            end
            ubxfr_pkg::S_CK_CAP:
            begin
                idx_next = idx_reg + CW'(1);
                if (idx_reg < ck_pos)
                begin
                    fl_ctrl.add = 1'b1;
                end
                else if (idx_reg == ck_pos)
                begin
                    cka_next = ram_rdata;
                end
                else if ((cka_reg == fl_a) && (ram_rdata == fl_b))
                begin
                    rv_next    = 1'b1;
                    rm_next    = filter_pass;
                    rcls_next  = cls_reg;
                    rid_next   = ident_reg;
                    rlen_next  = 8'(spl_reg);
                    count_next = '0;
                    phase_next = ubxfr_pkg::PH_SEEK;
                end
                else
                begin
                    idx_next = CW'(1);
                    if (err_reg == ubxfr_pkg::ERR_NONE)
                    begin
                        err_next = ubxfr_pkg::ERR_CHECK;
                    end
                end
            end
            ubxfr_pkg::S_SCAN_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    // no further start byte retained
                    count_next = '0;
                    phase_next = ubxfr_pkg::PH_SEEK;
                end
            end
            ubxfr_pkg::S_SCAN_CAP:
            begin
                if (ram_rdata == ubxfr_pkg::SYNC_FIRST)
                begin
                    shift_next = idx_reg;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ubxfr_pkg::S_MOVE_RD:
            begin
                ram_raddr = AW'(idx_reg + shift_reg);
                if (idx_reg >= count_reg - shift_reg)
                begin
                    count_next = count_reg - shift_reg;
                    phase_next = ubxfr_pkg::PH_HEADER;
                end
            end
            ubxfr_pkg::S_MOVE_CAP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[AW-1:0];
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ubxfr_pkg::S_IDLE;
            phase_reg <= ubxfr_pkg::PH_SEEK;
            count_reg <= '0;
            spl_reg   <= '0;
            idx_reg   <= '0;
            shift_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            spl_reg   <= spl_next;
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            if (emit_go)
            begin
                mv_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mv_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        byte_reg  <= byte_next;
        off_reg   <= off_next;
        sync2_reg <= sync2_next;
        cls_reg   <= cls_next;
        ident_reg <= ident_next;
        lenlo_reg <= lenlo_next;
        lenhi_reg <= lenhi_next;
        cka_reg   <= cka_next;
        rv_reg    <= rv_next;
        rm_reg    <= rm_next;
        rcls_reg  <= rcls_next;
        rid_reg   <= rid_next;
        rlen_reg  <= rlen_next;
        err_reg   <= err_next;
        rdat_reg  <= rdat_next;
        rok_reg   <= rok_next;
        if (emit_go)
        begin
            md_reg <= {3'd0, rok_reg, rdat_reg, err_reg, rlen_reg, rid_reg, rcls_reg,
                       rm_reg, rv_reg};
        end
    end

    assign s_tready = (state_reg == ubxfr_pkg::S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

@@ hw/rtl/ubxfr_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module ubxfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ubxfr_fletcher.sv @@
// running 8-bit fletcher sums, one byte per add
// depends on ubxfr_pkg
module ubxfr_fletcher (
    input  logic                clk,
    input  logic                rst_n,
    input  ubxfr_pkg::fl_ctrl_t ctrl,
    input  logic [7:0]          data,
    output logic [7:0]          sum_a,
    output logic [7:0]          sum_b
);

    logic [7:0] a_reg, a_next;
    logic [7:0] b_reg, b_next;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (ctrl.clr)
        begin
            a_next = 8'd0;
            b_next = 8'd0;
        end
        else if (ctrl.add)
        begin
            a_next = a_reg + data;
            b_next = b_reg + a_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 8'd0;
            b_reg <= 8'd0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign sum_a = a_reg;
    assign sum_b = b_reg;

endmodule

@@ hw/rtl/ubxfr_checker.sv @@
// port-level checks of the frame receiver, bound to the top level
// depends on ubx_frame_receiver ports only
module ubxfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one beat in work at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat taken while busy");

    // a read result never carries a frame
    a_read_vs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[36] && m_tdata[0]))
        else $error("read and frame reported together");

    // a filter match needs a valid frame
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("match without valid frame");

    // failed read returns zero
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[36] |-> m_tdata[35:28] == 8'd0)
        else $error("read data without read_ok");

endmodule

bind ubx_frame_receiver ubxfr_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/tb_ubx_frame_receiver.sv @@
// testbench of the binary frame receiver: directed table, then random frame traffic
// checked beat by beat against a predictor; depends on ubxfr_pkg and ubx_frame_receiver
module tb_ubx_frame_receiver;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_BYTES   = 256;
    localparam int CYCLE_LIMIT = 1000000;

    // result beat, laid out exactly as m_tdata (lowest field last)
    typedef struct packed {
        logic [2:0] pad;
        logic       read_ok;
        logic [7:0] read_data;
        logic [1:0] error_code;
        logic [7:0] frame_payload_len;
        logic [7:0] msg_ident;
        logic [7:0] msg_class;
        logic       frame_match;
        logic       frame_valid;
    } result_t;

    // one input beat; has_fixed marks a row whose result is typed in
    typedef struct {
        logic       cmd;
        logic [7:0] rx_byte;
        logic [7:0] read_offset;
        logic       has_fixed;
        result_t    fixed;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // rx_byte [7:0], read_offset [15:8]
    logic        s_tuser = 1'b0; // cmd [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // frame_valid [0], frame_match [1], msg_class [9:2], msg_ident [17:10],
    // frame_payload_len [25:18], error_code [27:26], read_data [35:28], read_ok [36]
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    ubx_frame_receiver #(.BUFFER_BYTES(BUF_BYTES)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: a shadow of the frame store and the parser
    // ---------------------------------------------------------------
    logic [7:0]        shadow_store [BUF_BYTES];
    bit                shadow_written [BUF_BYTES];
    ubxfr_pkg::phase_t rx_phase;
    int                held_bytes;
    int                held_len;
    logic [7:0]        class_sel;
    logic [7:0]        ident_sel;

    result_t    pending_results [$];
    int         sender_idle_pct;
    int         receiver_stall_pct;
    bit         any_failure;
    int         cycle_count;
    int         frames_seen;
    int         errors_seen;
    int         reads_hit;
    int         beats_sent;

    // drop everything before the next retained start byte
    function automatic void shift_to_next_sync();
        for (int k = 1; k < held_bytes && k < BUF_BYTES; k++)
        begin
            if (shadow_store[k] == ubxfr_pkg::SYNC_FIRST)
            begin
                for (int j = 0; j < held_bytes - k; j++)
                begin
                    shadow_store[j]   = shadow_store[j + k];
                    shadow_written[j] = 1'b1;
                end
                held_bytes -= k;
                rx_phase = ubxfr_pkg::PH_HEADER;
                return;
            end
        end
        held_bytes = 0;
        rx_phase = ubxfr_pkg::PH_SEEK;
    endfunction

    // run header and checksum checks until more bytes are needed
    function automatic void parse_held(ref result_t res);
        int         total;
        int         ck_pos;
        int         hdr_len;
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        forever
        begin
            if (rx_phase == ubxfr_pkg::PH_HEADER)
            begin
                if (held_bytes < ubxfr_pkg::FRAME_OVERHEAD)
                    return;
                if (shadow_store[1] != ubxfr_pkg::SYNC_SECOND)
                begin
                    if (res.error_code == ubxfr_pkg::ERR_NONE)
                        res.error_code = ubxfr_pkg::ERR_SYNC;
                    shift_to_next_sync();
                    continue;
                end
                hdr_len = {shadow_store[5], shadow_store[4]};
                if (hdr_len + ubxfr_pkg::FRAME_OVERHEAD > BUF_BYTES)
                begin
                    if (res.error_code == ubxfr_pkg::ERR_NONE)
                        res.error_code = ubxfr_pkg::ERR_LONG;
                    shift_to_next_sync();
                    continue;
                end
                held_len = hdr_len;
                rx_phase = ubxfr_pkg::PH_BODY;
            end
            else if (rx_phase == ubxfr_pkg::PH_BODY)
            begin
                total = held_len + ubxfr_pkg::FRAME_OVERHEAD;
                if (held_bytes < total)
                    return;
                ck_pos = ubxfr_pkg::PAYLOAD_START + held_len;
                sum_a = 8'd0;
                sum_b = 8'd0;
                for (int k = 2; k < ck_pos; k++)
                begin
                    sum_a = sum_a + shadow_store[k];
                    sum_b = sum_b + sum_a;
                end
                if (shadow_store[ck_pos] != sum_a || shadow_store[ck_pos + 1] != sum_b)
                begin
                    if (res.error_code == ubxfr_pkg::ERR_NONE)
                        res.error_code = ubxfr_pkg::ERR_CHECK;
                    shift_to_next_sync();
                    continue;
                end
                res.frame_valid       = 1'b1;
                res.frame_match       = (class_sel == ubxfr_pkg::FILTER_ANY
                                         || class_sel == shadow_store[2])
                                     && (ident_sel == ubxfr_pkg::FILTER_ANY
                                         || ident_sel == shadow_store[3]);
                res.msg_class         = shadow_store[2];
                res.msg_ident         = shadow_store[3];
                res.frame_payload_len = held_len[7:0];
                held_bytes = 0;
                rx_phase = ubxfr_pkg::PH_SEEK;
                return;
            end
            else
                return;
        end
    endfunction

    // expected result of one accepted beat; updates the shadow state
    function automatic result_t predict_beat(logic cmd, logic [7:0] rx, logic [7:0] off);
        result_t res;
        res = '0;
        if (cmd)
        begin
            if (off < held_len && ubxfr_pkg::PAYLOAD_START + off < BUF_BYTES)
            begin
                res.read_data = shadow_store[ubxfr_pkg::PAYLOAD_START + off];
                res.read_ok   = 1'b1;
            end
            return res;
        end
        if (rx_phase == ubxfr_pkg::PH_SEEK)
        begin
            if (rx == ubxfr_pkg::SYNC_FIRST)
            begin
                shadow_store[0]   = rx;
                shadow_written[0] = 1'b1;
                held_bytes = 1;
                rx_phase = ubxfr_pkg::PH_HEADER;
            end
            return res;
        end
        if (held_bytes >= BUF_BYTES)
        begin
            held_bytes = 0;
            rx_phase = ubxfr_pkg::PH_SEEK;
            return res;
        end
        shadow_store[held_bytes]   = rx;
        shadow_written[held_bytes] = 1'b1;
        held_bytes++;
        parse_held(res);
        return res;
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    task automatic send_beat(beat_t b);
        result_t predicted;
        // never read a store entry that was not written since reset
        if (b.cmd && b.read_offset < held_len
            && !shadow_written[ubxfr_pkg::PAYLOAD_START + b.read_offset])
            b.read_offset = 8'hFF;
        s_tvalid <= 1'b1;
        s_tuser  <= b.cmd;
        s_tdata  <= {b.read_offset, b.rx_byte};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = predict_beat(b.cmd, b.rx_byte, b.read_offset);
        pending_results.insert(pending_results.size(), b.has_fixed ? b.fixed : predicted);
        beats_sent++;
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic send_byte(logic [7:0] v);
        beat_t b;
        b = '{cmd: 1'b0, rx_byte: v, read_offset: 8'($urandom), has_fixed: 1'b0, fixed: '0};
        send_beat(b);
    endtask

    task automatic send_read(logic [7:0] off);
        beat_t b;
        b = '{cmd: 1'b1, rx_byte: 8'($urandom), read_offset: off, has_fixed: 1'b0, fixed: '0};
        send_beat(b);
    endtask

    // wait until every result is back and the sequencer has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_filter(logic addr, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (addr == ubxfr_pkg::CFG_CLASS)
            class_sel = value;
        else
            ident_sel = value;
    endtask

    // one frame with random content; kind selects the corruption
    task automatic send_frame(int kind);
        logic [7:0] bytes [$];
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        int         len;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            len = 248;
        else if (pick < 10)
            len = $urandom_range(11, 60);
        else
            len = $urandom_range(0, 10);
        if (kind == 3)
            len = $urandom_range(249, 65535);
        bytes.insert(bytes.size(), ubxfr_pkg::SYNC_FIRST);
        bytes.insert(bytes.size(),
                     kind == 2 ? 8'($urandom_range(0, 255) ^ 1) : ubxfr_pkg::SYNC_SECOND);
        if (kind == 2 && bytes[1] == ubxfr_pkg::SYNC_SECOND)
            bytes[1] = 8'h63;
        bytes.insert(bytes.size(), $urandom_range(0, 2) == 0 ? class_sel : 8'($urandom));
        bytes.insert(bytes.size(), $urandom_range(0, 2) == 0 ? ident_sel : 8'($urandom));
        bytes.insert(bytes.size(), len[7:0]);
        bytes.insert(bytes.size(), len[15:8]);
        for (int k = 0; k < len && k < 248; k++)
            bytes.insert(bytes.size(), 8'($urandom));
        sum_a = 8'd0;
        sum_b = 8'd0;
        for (int k = 2; k < bytes.size(); k++)
        begin
            sum_a = sum_a + bytes[k];
            sum_b = sum_b + sum_a;
        end
        if (kind == 1)
        begin
            // corrupt one of the two checksum bytes
            if ($urandom_range(0, 1))
                sum_a = sum_a ^ 8'($urandom_range(1, 255));
            else
                sum_b = sum_b ^ 8'($urandom_range(1, 255));
        end
        if (kind == 3)
        begin
            // oversize header: only a few trailing bytes follow
            sum_a = 8'($urandom);
            sum_b = 8'($urandom);
            while (bytes.size() > 6 + 4)
                void'(bytes.pop_back());
        end
        bytes.insert(bytes.size(), sum_a);
        bytes.insert(bytes.size(), sum_b);
        foreach (bytes[i])
        begin
            send_byte(bytes[i]);
            // live reads while the frame is still arriving
            if ($urandom_range(0, 99) < 4)
                send_read(8'($urandom_range(0, 15)));
        end
    endtask

    task automatic random_traffic(int beats);
        int start;
        int pick;
        start = beats_sent;
        while (beats_sent - start < beats)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(0);
            else if (pick < 63)
                send_frame(1);
            else if (pick < 68)
                send_frame(2);
            else if (pick < 72)
                send_frame(3);
            else if (pick < 85)
            begin
                // line noise, start bytes mixed in now and then
                repeat ($urandom_range(1, 4))
                    send_byte($urandom_range(0, 4) == 0 ? ubxfr_pkg::SYNC_FIRST
                                                        : 8'($urandom));
            end
            else
                send_read($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 12)));
        end
    endtask

    function automatic result_t frame_result(logic [7:0] cls, logic [7:0] ident);
        result_t r;
        r = '0;
        r.frame_valid = 1'b1;
        r.frame_match = 1'b1;
        r.msg_class   = cls;
        r.msg_ident   = ident;
        return r;
    endfunction

    function automatic result_t error_result(logic [1:0] code);
        result_t r;
        r = '0;
        r.error_code = code;
        return r;
    endfunction

    // directed rows: two empty reads, a stray byte, a zero-length frame, a bad second sync
    // byte and a bad checksum, each error reported at the eighth byte
    task automatic directed_table();
        beat_t rows [$];
        logic [7:0] good [8];
        logic [7:0] bad_sync [8];
        logic [7:0] bad_ck [8];
        good     = '{8'hB5, 8'h62, 8'h01, 8'h02, 8'h00, 8'h00, 8'h03, 8'h0A};
        bad_sync = '{8'hB5, 8'h63, 8'h01, 8'h02, 8'h00, 8'h00, 8'h03, 8'h0A};
        bad_ck   = '{8'hB5, 8'h62, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h0F};
        // nothing stored after reset: read returns zero
        rows.insert(rows.size(), '{1'b1, 8'h00, 8'hFF, 1'b1, result_t'('0)});
        rows.insert(rows.size(), '{1'b1, 8'hFF, 8'h00, 1'b1, result_t'('0)});
        rows.insert(rows.size(), '{1'b0, 8'h00, 8'h00, 1'b1, result_t'('0)});
        foreach (good[i])
            rows.insert(rows.size(), '{1'b0, good[i], 8'h00, i == 7,
                        i == 7 ? frame_result(8'h01, 8'h02) : result_t'('0)});
        foreach (bad_sync[i])
            rows.insert(rows.size(), '{1'b0, bad_sync[i], 8'h00, i == 7,
                        i == 7 ? error_result(ubxfr_pkg::ERR_SYNC) : result_t'('0)});
        foreach (bad_ck[i])
            rows.insert(rows.size(), '{1'b0, bad_ck[i], 8'h00, i == 7,
                        i == 7 ? error_result(ubxfr_pkg::ERR_CHECK) : result_t'('0)});
        foreach (rows[i])
            send_beat(rows[i]);
    endtask

    // ---------------------------------------------------------------
    // output side: one check per accepted result beat
    // ---------------------------------------------------------------
    task automatic check_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            any_failure = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation waiting: %h", m_tdata);
                any_failure = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("frame_valid", want.frame_valid, got.frame_valid);
                check_field("frame_match", want.frame_match, got.frame_match);
                check_field("msg_class", want.msg_class, got.msg_class);
                check_field("msg_ident", want.msg_ident, got.msg_ident);
                check_field("frame_payload_len", want.frame_payload_len, got.frame_payload_len);
                check_field("error_code", want.error_code, got.error_code);
                check_field("read_data", want.read_data, got.read_data);
                check_field("read_ok", want.read_ok, got.read_ok);
                frames_seen += want.frame_valid;
                errors_seen += (want.error_code != ubxfr_pkg::ERR_NONE);
                reads_hit   += want.read_ok;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // hard stop for a hung handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // run sequence
    // ---------------------------------------------------------------
    initial
    begin
        any_failure = 1'b0;
        cycle_count = 0;
        frames_seen = 0;
        errors_seen = 0;
        reads_hit   = 0;
        beats_sent  = 0;
        rx_phase    = ubxfr_pkg::PH_SEEK;
        held_bytes  = 0;
        held_len    = 0;
        class_sel   = ubxfr_pkg::FILTER_ANY;
        ident_sel   = ubxfr_pkg::FILTER_ANY;
        foreach (shadow_written[i])
            shadow_written[i] = 1'b0;
        // sender idles 30 in 100, receiver stalls 84 in 100
        sender_idle_pct    = 30;
        receiver_stall_pct = 84;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // filters at reset value (both wildcards)
        directed_table();
        drain();

        // six phases across the filter extremes; idling swaps at phase two and stops at phase four
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_filter(ubxfr_pkg::CFG_CLASS, 8'h00);
                    write_filter(ubxfr_pkg::CFG_IDENT, 8'h00);
                end
                1:
                begin
                    write_filter(ubxfr_pkg::CFG_CLASS, ubxfr_pkg::FILTER_ANY);
                    write_filter(ubxfr_pkg::CFG_IDENT, 8'($urandom));
                end
                2:
                begin
                    write_filter(ubxfr_pkg::CFG_CLASS, 8'($urandom));
                    write_filter(ubxfr_pkg::CFG_IDENT, ubxfr_pkg::FILTER_ANY);
                end
                3:
                begin
                    write_filter(ubxfr_pkg::CFG_CLASS, 8'hFE);
                    write_filter(ubxfr_pkg::CFG_IDENT, 8'hFE);
                end
                4:
                begin
                    write_filter(ubxfr_pkg::CFG_CLASS, 8'($urandom));
                    write_filter(ubxfr_pkg::CFG_IDENT, 8'($urandom));
                end
                default:
                begin
                    write_filter(ubxfr_pkg::CFG_CLASS, ubxfr_pkg::FILTER_ANY);
                    write_filter(ubxfr_pkg::CFG_IDENT, ubxfr_pkg::FILTER_ANY);
                end
            endcase
            if (p == 2)
            begin
                sender_idle_pct    = 84;
                receiver_stall_pct = 30;
            end
            else if (p == 4)
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            random_traffic(100);
            drain();
        end

        $display("covered %0d beats: %0d good frames, %0d framing errors, %0d payload reads",
                 beats_sent, frames_seen, errors_seen, reads_hit);
        $display("filters swept through wildcard, zero, 0xfe and random settings");
        if (!any_failure)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
